// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

// ===== rtl/pfl_pkg.sv =====
// Package for the per-core page free-list allocator: field widths, codes,
// microcode word type and the microcode ROM. No dependencies.
`default_nettype none

package pfl_pkg;

    localparam int ADDR_W     = 40;
    localparam int CORE_IN_W  = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int STEP_W     = 3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

    localparam logic [ADDR_W-1:0] REGION_BASE_RST  = 40'd0;
    localparam logic [ADDR_W-1:0] REGION_LIMIT_RST = 40'd134217728;

    // Program addresses
    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_FCHK  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_FPUSH = 3'd2;
    localparam logic [STEP_W-1:0] STEP_ASEL  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_APOP  = 3'd4;

    typedef enum logic [1:0] {
        JMP_NEXT  = 2'd0,   // fall through
        JMP_CMD   = 2'd1,   // free: next, alloc: target
        JMP_FOUND = 2'd2,   // list found: next, else target
        JMP_ALWAYS = 2'd3   // go to target
    } t_jump;

    typedef struct packed {
        logic                latch;     // take an input item
        logic                check;     // first half of free address check
        logic                push;      // finish free, emit result
        logic                select;    // pick list, start next-page read
        logic                pop;       // update head, emit grant
        logic                wait_out;  // hold until output register is free
        t_jump               jump;
        logic [STEP_W-1:0]   target;
    } t_uop;

    typedef struct packed {
        logic in_valid;
        logic cmd_free;
        logic found;
        logic out_free;
    } t_seq_cond;

    typedef struct packed {
        t_uop uop;
        logic fire;     // current step executes this cycle
    } t_ctrl;

    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '0;
        u.jump   = JMP_ALWAYS;
        u.target = STEP_IDLE;
        case (step)
            STEP_IDLE: begin
                u.latch  = 1'b1;
                u.jump   = JMP_CMD;
                u.target = STEP_ASEL;
            end
            STEP_FCHK: begin
                u.check = 1'b1;
                u.jump  = JMP_NEXT;
            end
            STEP_FPUSH: begin
                u.push     = 1'b1;
                u.wait_out = 1'b1;
            end
            STEP_ASEL: begin
                u.select   = 1'b1;
                u.wait_out = 1'b1;
                u.jump     = JMP_FOUND;
            end
            STEP_APOP: begin
                u.pop      = 1'b1;
                u.wait_out = 1'b1;
            end
            default: begin
                u.jump = JMP_ALWAYS;
            end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pfl_seq.sv =====
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on pfl_pkg (ucode ROM, control types).
`default_nettype none

module pfl_seq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pfl_pkg::t_seq_cond  i_cond,
    output pfl_pkg::t_ctrl           o_ctrl
);

    logic [pfl_pkg::STEP_W-1:0] r_step;
    logic [pfl_pkg::STEP_W-1:0] n_step;
    pfl_pkg::t_uop              w_uop;
    logic                       w_hold;

    assign w_uop  = pfl_pkg::ucode(r_step);
    assign w_hold = (w_uop.latch && !i_cond.in_valid) ||
                    (w_uop.wait_out && !i_cond.out_free);

    always_comb begin
        n_step = r_step;
        if (!w_hold) begin
            case (w_uop.jump)
                pfl_pkg::JMP_NEXT:  n_step = r_step + pfl_pkg::STEP_W'(1);
                pfl_pkg::JMP_CMD:   n_step = i_cond.cmd_free ?
                                             r_step + pfl_pkg::STEP_W'(1) : w_uop.target;
                pfl_pkg::JMP_FOUND: n_step = i_cond.found ?
                                             r_step + pfl_pkg::STEP_W'(1) : w_uop.target;
                default:            n_step = w_uop.target;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= pfl_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl.uop  = w_uop;
    assign o_ctrl.fire = !w_hold;

endmodule

`default_nettype wire

// ===== rtl/pfl_mem.sv =====
// Next-page link store: one write port, one registered read port.
// No dependencies.
`default_nettype none

module pfl_mem #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15,
    parameter int DW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/pfl_heads.sv =====
// List head registers (valid flag + page per core) and the list selector:
// own core first, else lowest-numbered non-empty core. No package use.
`default_nettype none

module pfl_heads #(
    parameter int CORES  = 8,
    parameter int CORE_W = 3,
    parameter int PAGE_W = 15
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CORE_W-1:0] i_core,
    input  wire logic              i_wr_en,
    input  wire logic [CORE_W-1:0] i_wr_core,
    input  wire logic              i_wr_valid,
    input  wire logic [PAGE_W-1:0] i_wr_page,
    output logic                   o_own_valid,
    output logic                   o_found,
    output logic      [CORE_W-1:0] o_sel_core,
    output logic      [PAGE_W-1:0] o_sel_page
);

    logic [CORES-1:0]  r_valid;
    logic [PAGE_W-1:0] r_page [CORES];
    logic [CORE_W-1:0] w_sel;
    logic              w_found;

    always_comb begin
        w_found = 1'b0;
        w_sel   = i_core;
        for (int k = CORES - 1; k >= 0; k--) begin
            if (r_valid[k]) begin
                w_found = 1'b1;
                w_sel   = CORE_W'(k);
            end
        end
        if (r_valid[i_core]) begin
            w_sel = i_core;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_core] <= i_wr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_page[i_wr_core] <= i_wr_page;
        end
    end

    assign o_own_valid = r_valid[i_core];
    assign o_found     = w_found;
    assign o_sel_core  = w_sel;
    assign o_sel_page  = r_page[w_sel];

endmodule

`default_nettype wire

// ===== rtl/per_core_page_free_list_allocator_core.sv =====
// Top level of the per-core page free-list allocator.
// Depends on pfl_pkg, pfl_seq, pfl_heads, pfl_mem and assert_macros.svh.
// Request channel (i_in_valid / o_in_stall): command (0 allocate, 1 free),
//   core number and, for free, a page byte address.
// Result channel (o_out_valid / i_out_stall): one item per request, a status
//   (0 ok, 1 no free page, 2 bad free address) and the granted address
//   (0 on free and on a failed allocate).
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 writes
//   region_base, index 1 writes region_limit. Write only while idle.
// Sequence: a microcoded program that accepts, then runs two steps per
//   command. Free splits the address check over two steps (the 40-bit
//   compares); allocate picks a list, then uses the registered next-page
//   read. The result register loads at the end of a command's second
//   step and the next item is accepted after it: one item at a time. An
//   allocate that finds every list empty reports at its list-select step
//   and then returns to accept.
// Stalls: the next item is accepted while a result still waits; a result
//   step holds while the output register is full and stalled.
// Reset: synchronous, active low: all lists empty, region_base 0,
//   region_limit 128 MiB, no result pending. Link memory needs no clearing.
`default_nettype none

module per_core_page_free_list_allocator_core #(
    parameter int CORES      = 8,
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 32768
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_command,
    input  wire logic [pfl_pkg::CORE_IN_W-1:0]   i_core,
    input  wire logic [pfl_pkg::ADDR_W-1:0]      i_page_address,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [pfl_pkg::STATUS_W-1:0]    o_status,
    output logic      [pfl_pkg::ADDR_W-1:0]      o_granted_address,
    // config channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pfl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pfl_pkg::ADDR_W-1:0]      i_cfg_data
);

`include "assert_macros.svh"

    localparam int CORE_W     = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int HI_W       = pfl_pkg::ADDR_W - PAGE_SHIFT;
    localparam int LINK_W     = PAGE_W + 1;

    // config registers
    logic [pfl_pkg::ADDR_W-1:0]   r_base;
    logic [pfl_pkg::ADDR_W-1:0]   r_limit;

    // latched request
    logic [CORE_W-1:0]            r_core;
    logic [pfl_pkg::ADDR_W-1:0]   r_addr;
    logic                         r_bad;

    // allocate working registers
    logic [CORE_W-1:0]            r_tgt;
    logic [PAGE_W-1:0]            r_page;

    // output register
    logic                         r_out_valid;
    logic [pfl_pkg::STATUS_W-1:0] r_status;
    logic [pfl_pkg::ADDR_W-1:0]   r_granted;
    logic                         n_out_valid;

    pfl_pkg::t_seq_cond           w_cond;
    pfl_pkg::t_ctrl               w_ctrl;

    logic [CORE_W-1:0]            w_core_idx;
    logic                         w_accept;
    logic                         w_out_free;
    logic                         w_own_valid;
    logic                         w_found;
    logic [CORE_W-1:0]            w_sel_core;
    logic [PAGE_W-1:0]            w_sel_page;
    logic [LINK_W-1:0]            w_rdata;
    logic [PAGE_W-1:0]            w_free_page;
    logic                         w_free_bad;
    logic                         w_push_do;
    logic                         w_pop_do;
    logic                         w_sel_do;
    logic                         w_emit;
    logic                         w_hd_we;
    logic [CORE_W-1:0]            w_hd_core;
    logic                         w_hd_valid;
    logic [PAGE_W-1:0]            w_hd_page;

    // core number reduced modulo CORES (3-bit value, small table)
    always_comb begin
        w_core_idx = '0;
        for (int k = 0; k < (1 << pfl_pkg::CORE_IN_W); k++) begin
            if (i_core == pfl_pkg::CORE_IN_W'(k)) begin
                w_core_idx = CORE_W'(k % CORES);
            end
        end
    end

    // ---------------- sequencer ----------------
    assign w_out_free      = !r_out_valid || !i_out_stall;
    assign w_cond.in_valid = i_in_valid;
    assign w_cond.cmd_free = (i_command == pfl_pkg::CMD_FREE);
    assign w_cond.found    = w_found;
    assign w_cond.out_free = w_out_free;

    pfl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (w_cond),
        .o_ctrl  (w_ctrl)
    );

    assign o_in_stall = !w_ctrl.uop.latch;
    assign w_accept   = w_ctrl.fire && w_ctrl.uop.latch;
    assign w_push_do  = w_ctrl.fire && w_ctrl.uop.push;
    assign w_pop_do   = w_ctrl.fire && w_ctrl.uop.pop;
    assign w_sel_do   = w_ctrl.fire && w_ctrl.uop.select;
    assign w_emit     = w_push_do || w_pop_do || (w_sel_do && !w_found);

    // ---------------- free address check ----------------
    assign w_free_page = r_addr[PAGE_SHIFT +: PAGE_W];
    // second half of the check: the limit compare
    assign w_free_bad  = r_bad || (r_addr >= r_limit);

    // ---------------- list heads ----------------
    // free writes own head with the pushed page; allocate writes the
    // popped list's head with the link read from memory
    always_comb begin
        w_hd_we    = 1'b0;
        w_hd_core  = r_core;
        w_hd_valid = 1'b1;
        w_hd_page  = w_free_page;
        if (w_push_do && !w_free_bad) begin
            w_hd_we = 1'b1;
        end else if (w_pop_do) begin
            w_hd_we    = 1'b1;
            w_hd_core  = r_tgt;
            w_hd_valid = w_rdata[PAGE_W];
            w_hd_page  = w_rdata[PAGE_W-1:0];
        end
    end

    pfl_heads #(
        .CORES  (CORES),
        .CORE_W (CORE_W),
        .PAGE_W (PAGE_W)
    ) u_heads (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_core      (r_core),
        .i_wr_en     (w_hd_we),
        .i_wr_core   (w_hd_core),
        .i_wr_valid  (w_hd_valid),
        .i_wr_page   (w_hd_page),
        .o_own_valid (w_own_valid),
        .o_found     (w_found),
        .o_sel_core  (w_sel_core),
        .o_sel_page  (w_sel_page)
    );

    // ---------------- next-page links ----------------
    // link = {valid, page}; on push it records the old own head, which is
    // the selected page whenever the own list is non-empty
    pfl_mem #(
        .DEPTH (MAX_PAGES),
        .AW    (PAGE_W),
        .DW    (LINK_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_push_do && !w_free_bad),
        .i_waddr (w_free_page),
        .i_wdata ({w_own_valid, w_sel_page}),
        .i_re    (w_sel_do && w_found),
        .i_raddr (w_sel_page),
        .o_rdata (w_rdata)
    );

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_core <= w_core_idx;
            r_addr <= i_page_address;
        end
        if (w_ctrl.fire && w_ctrl.uop.check) begin
            r_bad <= (|r_addr[PAGE_SHIFT-1:0]) ||
                     (r_addr < r_base) ||
                     (r_addr[pfl_pkg::ADDR_W-1:PAGE_SHIFT] >= HI_W'(MAX_PAGES));
        end
        if (w_sel_do) begin
            r_tgt  <= w_sel_core;
            r_page <= w_sel_page;
        end
    end

    // ---------------- config ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= pfl_pkg::REGION_BASE_RST;
            r_limit <= pfl_pkg::REGION_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pfl_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                pfl_pkg::CFG_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (w_push_do) begin
                r_status  <= w_free_bad ? pfl_pkg::STATUS_BAD : pfl_pkg::STATUS_OK;
                r_granted <= '0;
            end else if (w_pop_do) begin
                r_status  <= pfl_pkg::STATUS_OK;
                r_granted <= pfl_pkg::ADDR_W'(r_page) << PAGE_SHIFT;
            end else begin
                r_status  <= pfl_pkg::STATUS_NONE;
                r_granted <= '0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_address = r_granted;

    // ---------------- checks ----------------
    `ASSERT_IMPLY(a_emit_into_free_slot, i_clk, i_rst_n, w_emit, (!r_out_valid || !i_out_stall))
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, o_in_stall)
    `ASSERT_IMPLY(a_pop_needs_found, i_clk, i_rst_n, w_pop_do, !w_sel_do)
    `ASSERT_IMPLY(a_no_grant_on_fail, i_clk, i_rst_n, (r_out_valid && (r_status != pfl_pkg::STATUS_OK)), (r_granted == '0))

endmodule

`default_nettype wire

// ===== bench/page_grant_checker.sv =====
// Checker for the per-core page allocator: watches the request, result and
// register channels, predicts each result and compares it.
// Depends on pfl_pkg.
`default_nettype none

module page_grant_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic                           i_command,
    input  wire logic [pfl_pkg::CORE_IN_W-1:0]  i_core,
    input  wire logic [pfl_pkg::ADDR_W-1:0]     i_page_address,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [pfl_pkg::STATUS_W-1:0]   i_status,
    input  wire logic [pfl_pkg::ADDR_W-1:0]     i_granted_address,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [pfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pfl_pkg::ADDR_W-1:0]     i_cfg_data,
    output int                                  o_mismatches,
    output int                                  o_outstanding
);
    import pfl_pkg::*;

    localparam int CORES      = 8;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = 15;
    localparam int PAGES      = 1 << PAGE_W;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   granted;
    } grant_t;

    // links: {on list, page number}
    logic [PAGE_W:0]     head_link  [CORES];
    logic [PAGE_W:0]     page_below [PAGES];
    logic [ADDR_W-1:0]   base_addr;
    logic [ADDR_W-1:0]   limit_addr;
    grant_t              grants_due [$];

    function automatic logic pop_page(input int c, output logic [PAGE_W-1:0] page);
        page = '0;
        if (!head_link[c][PAGE_W])
            return 1'b0;
        page = head_link[c][PAGE_W-1:0];
        head_link[c] = page_below[page];
        return 1'b1;
    endfunction

    function automatic grant_t serve_request(input logic cmd, input logic [CORE_IN_W-1:0] core,
                                             input logic [ADDR_W-1:0] addr);
        grant_t              r;
        logic [PAGE_W-1:0]   page;
        logic                got;
        int                  c;
        r.status  = STATUS_OK;
        r.granted = '0;
        page = addr[PAGE_SHIFT +: PAGE_W];
        if (cmd == CMD_FREE) begin
            if (addr[PAGE_SHIFT-1:0] != '0 || addr < base_addr || addr >= limit_addr ||
                addr[ADDR_W-1:PAGE_SHIFT+PAGE_W] != '0) begin
                r.status = STATUS_BAD;
            end else begin
                page_below[page] = head_link[core];
                head_link[core]  = {1'b1, page};
            end
        end else begin
            got = pop_page(core, page);
            // steal from the lowest-numbered other core that has a page
            for (c = 0; c < CORES && !got; c++) begin
                if (c != core)
                    got = pop_page(c, page);
            end
            if (got)
                r.granted[PAGE_SHIFT +: PAGE_W] = page;
            else
                r.status = STATUS_NONE;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        grant_t want;
        int     k;
        if (!i_rst_n) begin
            for (k = 0; k < CORES; k++)
                head_link[k] = '0;
            base_addr  = REGION_BASE_RST;
            limit_addr = REGION_LIMIT_RST;
            grants_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (grants_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d addr %h",
                             $time, i_status, i_granted_address);
                    o_mismatches++;
                end else begin
                    want = grants_due.pop_front();
                    if (i_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, i_status);
                        o_mismatches++;
                    end
                    if (i_granted_address !== want.granted) begin
                        $display("%0t: granted address mismatch, expected %h, actual %h",
                                 $time, want.granted, i_granted_address);
                        o_mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BASE: begin
                        base_addr = i_cfg_data;
                    end
                    CFG_LIMIT: begin
                        limit_addr = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall)
                grants_due.push_back(serve_request(i_command, i_core, i_page_address));
        end
        o_outstanding = grants_due.size();
    end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Top of the page allocator bench: clock, reset, request and register
// stimulus, result-side stalls and the verdict. Depends on pfl_pkg, the
// allocator RTL and page_grant_checker.
`default_nettype none

module testbench;
    import pfl_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [63:0] PAGE_BYTES  = 64'd4096;
    localparam logic [63:0] MEM_BYTES   = 64'd4096 * 64'd32768;   // top of page range
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   i_command      = CMD_ALLOC;
    logic [CORE_IN_W-1:0]   i_core         = '0;
    logic [ADDR_W-1:0]      i_page_address = '0;
    logic                   i_out_stall    = 1'b0;
    logic                   i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index    = CFG_BASE;
    logic [ADDR_W-1:0]      i_cfg_data     = '0;

    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [ADDR_W-1:0]      o_granted_address;
    logic                   o_cfg_ready;

    int                     mismatches;
    int                     outstanding;
    int unsigned            cycles = 0;

    // Stimulus-side copy of the region, used only to aim free addresses.
    logic [63:0]            base_now  = 64'(REGION_BASE_RST);
    logic [63:0]            limit_now = 64'(REGION_LIMIT_RST);

    // Written only by the stimulus process, read by the result-side process.
    bit                     quiet    = 1'b0;   // last part: no idling anywhere
    bit                     press_go = 1'b0;   // request one long result stall

    always #5 i_clk = ~i_clk;

    per_core_page_free_list_allocator_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_core            (i_core),
        .i_page_address    (i_page_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    page_grant_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_core            (i_core),
        .i_page_address    (i_page_address),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_status          (o_status),
        .i_granted_address (o_granted_address),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stall bursts between open runs,
    // one long hold when asked (fills the block so it stalls its input),
    // and no stalls at all once the last part of the run begins.
    initial begin : result_side
        int   run;
        logic level;
        bit   pressed;
        pressed = 1'b0;
        forever begin
            if (quiet) begin
                @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (press_go && !pressed) begin
                pressed = 1'b1;
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (79) @(negedge i_clk);
            end else begin
                if ($urandom_range(3, 0) == 0) begin
                    level = 1'b1;
                    run   = $urandom_range(18, 1);
                end else begin
                    level = 1'b0;
                    run   = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 20)
                                                        : $urandom_range(24, 1);
                end
                repeat (run) begin
                    @(negedge i_clk);
                    i_out_stall <= level;
                end
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[ADDR_W-1:0];
    endfunction

    // Free address aimed at the current region: mostly good pages (some from a
    // narrow window so pages get freed twice), plus pages just outside the
    // region, unaligned addresses and raw 40-bit noise.
    function automatic logic [ADDR_W-1:0] pick_free_address();
        logic [63:0] lo, hi, top_addr, pg;
        int          roll;
        roll     = $urandom_range(99, 0);
        top_addr = (limit_now < MEM_BYTES) ? limit_now : MEM_BYTES;
        lo       = (base_now + PAGE_BYTES - 1) / PAGE_BYTES;
        hi       = (top_addr == 0) ? 64'd0 : (top_addr - 1) / PAGE_BYTES;
        if (roll < 8 || top_addr == 0 || lo > hi)
            return rand_addr();
        if (roll < 14) begin
            // just below the base, or the first page at or past the top
            pg = (lo > 0 && roll < 11) ? lo - 1 : hi + 1;
            pg = pg * PAGE_BYTES;
            return pg[ADDR_W-1:0];
        end
        pg = lo + ($urandom % (hi - lo + 1));
        if (roll < 22) begin
            pg = pg * PAGE_BYTES + $urandom_range(4095, 1);
            return pg[ADDR_W-1:0];
        end
        if (roll < 45)
            pg = lo + $urandom_range(((hi - lo) < 15) ? int'(hi - lo) : 15, 0);
        pg = pg * PAGE_BYTES;
        return pg[ADDR_W-1:0];
    endfunction

    // Offer one item, with an optional idle burst first; returns on accept.
    task automatic put_request(input logic cmd, input logic [CORE_IN_W-1:0] c,
                               input logic [ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(4, 0) == 0)
            gap = $urandom_range(18, 1);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_core         <= c;
        i_page_address <= addr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic alloc_page(input logic [CORE_IN_W-1:0] c);
        put_request(CMD_ALLOC, c, rand_addr());
    endtask

    task automatic free_page(input logic [CORE_IN_W-1:0] c, input logic [ADDR_W-1:0] addr);
        put_request(CMD_FREE, c, addr);
    endtask

    // Stop offering and wait until every result has come back.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Region registers change only with the block drained.
    task automatic set_region(input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] l);
        drain();
        write_reg(CFG_BASE, b);
        write_reg(CFG_LIMIT, l);
        base_now  = 64'(b);
        limit_now = 64'(l);
    endtask

    // Random traffic in bursts: each burst leans to frees or to allocates and
    // favors one core, so lists fill, get stolen from and run dry.
    task automatic random_traffic(input int count, input bit with_pressure);
        int                   free_pct, burst_left, n;
        logic [CORE_IN_W-1:0] hot, c;
        logic                 cmd;
        burst_left = 0;
        free_pct   = 50;
        hot        = '0;
        for (n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(50, 10);
                case ($urandom_range(2, 0))
                    0: begin
                        free_pct = 75;
                    end
                    1: begin
                        free_pct = 30;
                    end
                    default: begin
                        free_pct = 50;
                    end
                endcase
                hot = CORE_IN_W'($urandom_range(7, 0));
            end
            burst_left--;
            if (with_pressure && n == 40)
                press_go = 1'b1;
            cmd = ($urandom_range(99, 0) < free_pct) ? CMD_FREE : CMD_ALLOC;
            c   = ($urandom_range(1, 0) != 0) ? hot : CORE_IN_W'($urandom_range(7, 0));
            if (cmd == CMD_FREE)
                free_page(c, pick_free_address());
            else
                alloc_page(c);
        end
    endtask

    initial begin : stimulus
        logic [63:0] b, l;
        int          k;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset region (0 .. 128 MiB).
        alloc_page(3'd0);                          // every list empty
        free_page(3'd3, 40'h0);                    // lowest page
        free_page(3'd3, 40'h00_07FF_F000);         // highest page
        free_page(3'd5, 40'h00_0800_0000);         // at the limit
        free_page(3'd1, 40'h00_0000_1001);         // unaligned
        free_page(3'd2, 40'hFF_FFFF_F000);         // aligned, far out of range
        free_page(3'd7, 40'hFF_FFFF_FFFF);         // all ones
        alloc_page(3'd3);                          // LIFO: highest page first
        alloc_page(3'd0);                          // steals page 0 from core 3
        alloc_page(3'd7);                          // empty again
        free_page(3'd7, 40'h0000_5000);
        free_page(3'd2, 40'h0000_6000);
        alloc_page(3'd4);                          // steal: core 2 before core 7
        alloc_page(3'd7);                          // own list
        free_page(3'd1, 40'h0000_9000);            // double free makes a cycle
        free_page(3'd1, 40'h0000_9000);
        alloc_page(3'd1);
        alloc_page(3'd1);
        free_page(3'd0, 40'h0000_9000);            // same page on two lists
        alloc_page(3'd1);
        alloc_page(3'd0);
        alloc_page(3'd5);

        random_traffic(180, 1'b0);

        // Widest region; the long result hold happens in here.
        set_region('0, ADDR_MAX);
        random_traffic(200, 1'b1);

        // Empty region: every free is bad, allocates drain what is left.
        set_region(ADDR_MAX, '0);
        random_traffic(120, 1'b0);

        // Single page region: page 0 freed over and over.
        set_region('0, 40'd4096);
        random_traffic(120, 1'b0);

        for (k = 0; k < 4; k++) begin
            b = $urandom_range(120 * 1024 * 1024, 0);
            if ($urandom_range(1, 0) != 0)
                b[11:0] = '0;
            l = b + $urandom_range(40 * 1024 * 1024, 1);
            if ($urandom_range(1, 0) != 0)
                l[11:0] = '0;
            set_region(b[ADDR_W-1:0], l[ADDR_W-1:0]);
            random_traffic(190, 1'b0);
        end

        // Last part: reset region again, no idling on either side.
        set_region('0, REGION_LIMIT_RST);
        quiet = 1'b1;
        random_traffic(150, 1'b0);

        drain();
        repeat (12) @(negedge i_clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
